/* design/kpv_pkg.sv */
`default_nettype none
package kpv_pkg;

	// Fixed-point format and datapath widths
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int DIV_W     = DATA_W + FRAC_BITS;
	localparam int CNT_W     = $clog2(DIV_W + 1);
	localparam int PC_W      = 7;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic [4:0] ridx_t;
	typedef logic [1:0] cfg_idx_t;
	typedef logic [PC_W-1:0] pc_t;

	localparam word_t WORD_MAX = 32'sh7fffffff;
	localparam word_t WORD_MIN = 32'sh80000000;
	localparam word_t Q_HALF   = word_t'(1 << (FRAC_BITS - 1));
	localparam word_t RESET_PROCESS = word_t'(((3 << FRAC_BITS) + 50) / 100);
	localparam word_t RESET_SENSOR  = word_t'(((1 << FRAC_BITS) + 5) / 10);
	localparam word_t RESET_COV     = Q_HALF;

	// Configuration register indexes
	localparam cfg_idx_t CFG_PROCESS = 2'd0;
	localparam cfg_idx_t CFG_SENSOR  = 2'd1;
	localparam cfg_idx_t CFG_INITCOV = 2'd2;

	// Result status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_SKIP = 2'd1;
	localparam logic [1:0] STAT_SAT  = 2'd2;

	// Register file map
	localparam ridx_t R_ZERO = 5'd0;
	localparam ridx_t R_POS  = 5'd1;
	localparam ridx_t R_VEL  = 5'd2;
	localparam ridx_t R_P00  = 5'd3;
	localparam ridx_t R_P01  = 5'd4;
	localparam ridx_t R_P10  = 5'd5;
	localparam ridx_t R_P11  = 5'd6;
	localparam ridx_t R_LFP  = 5'd7;
	localparam ridx_t R_QN   = 5'd8;
	localparam ridx_t R_RN   = 5'd9;
	localparam ridx_t R_HALF = 5'd10;
	localparam ridx_t R_DT   = 5'd11;
	localparam ridx_t R_U    = 5'd12;
	localparam ridx_t R_T0   = 5'd13;
	localparam ridx_t R_T1   = 5'd14;
	localparam ridx_t R_T2   = 5'd15;
	localparam ridx_t R_T3   = 5'd16;
	localparam ridx_t R_T4   = 5'd17;
	localparam ridx_t R_T5   = 5'd18;
	localparam ridx_t R_T6   = 5'd19;
	localparam ridx_t R_T7   = 5'd20;
	localparam ridx_t R_T8   = 5'd21;
	localparam ridx_t R_T9   = 5'd22;
	localparam ridx_t R_T10  = 5'd23;
	localparam ridx_t R_T11  = 5'd24;
	localparam ridx_t R_T12  = 5'd25;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_CHKZ = 3'd4
	} op_t;

	typedef struct packed {
		op_t   op;
		ridx_t dst;
		ridx_t sa;
		ridx_t sb;
		logic  last;
	} uop_t;

	typedef struct packed {
		logic  start;
		op_t   op;
		word_t a;
		word_t b;
	} alu_req_t;

	typedef struct packed {
		logic  done;
		word_t res;
		logic  sat;
	} alu_rsp_t;

	typedef struct packed {
		logic     alu_en;
		ridx_t    alu_idx;
		word_t    alu_data;
		logic     ld_en;
		word_t    ld_u;
		word_t    ld_dt;
		logic     cfg_en;
		cfg_idx_t cfg_idx;
		logic [DATA_W-2:0] cfg_data;
	} rf_wr_t;

	localparam pc_t PRED_START = 7'd0;
	localparam pc_t UPD_START  = 7'd20;

	function automatic uop_t mk_uop(input op_t op, input ridx_t d, input ridx_t a,
			input ridx_t b, input logic l);
		uop_t u;
		u.op   = op;
		u.dst  = d;
		u.sa   = a;
		u.sb   = b;
		u.last = l;
		return u;
	endfunction

	// Microprogram: predict from PRED_START, update from UPD_START
	function automatic uop_t ucode(input pc_t pc);
		uop_t u;
		case (pc)
			7'd0:  u = mk_uop(OP_MUL, R_T0,  R_DT,  R_DT,  1'b0);
			7'd1:  u = mk_uop(OP_MUL, R_T0,  R_T0,  R_U,   1'b0);
			7'd2:  u = mk_uop(OP_MUL, R_T0,  R_T0,  R_HALF, 1'b0);
			7'd3:  u = mk_uop(OP_MUL, R_T1,  R_VEL, R_DT,  1'b0);
			7'd4:  u = mk_uop(OP_ADD, R_T1,  R_POS, R_T1,  1'b0);
			7'd5:  u = mk_uop(OP_ADD, R_POS, R_T1,  R_T0,  1'b0);
			7'd6:  u = mk_uop(OP_MUL, R_T2,  R_DT,  R_U,   1'b0);
			7'd7:  u = mk_uop(OP_ADD, R_VEL, R_VEL, R_T2,  1'b0);
			7'd8:  u = mk_uop(OP_MUL, R_T3,  R_P10, R_DT,  1'b0);
			7'd9:  u = mk_uop(OP_ADD, R_T3,  R_P00, R_T3,  1'b0);
			7'd10: u = mk_uop(OP_MUL, R_T4,  R_P01, R_DT,  1'b0);
			7'd11: u = mk_uop(OP_ADD, R_T3,  R_T3,  R_T4,  1'b0);
			7'd12: u = mk_uop(OP_MUL, R_T4,  R_P11, R_DT,  1'b0);
			7'd13: u = mk_uop(OP_MUL, R_T4,  R_T4,  R_DT,  1'b0);
			7'd14: u = mk_uop(OP_ADD, R_T3,  R_T3,  R_T4,  1'b0);
			7'd15: u = mk_uop(OP_ADD, R_P00, R_T3,  R_QN,  1'b0);
			7'd16: u = mk_uop(OP_MUL, R_T4,  R_P11, R_DT,  1'b0);
			7'd17: u = mk_uop(OP_ADD, R_P01, R_P01, R_T4,  1'b0);
			7'd18: u = mk_uop(OP_ADD, R_P10, R_P10, R_T4,  1'b0);
			7'd19: u = mk_uop(OP_ADD, R_P11, R_P11, R_QN,  1'b1);
			// update: innovation matrix and its determinant
			7'd20: u = mk_uop(OP_ADD, R_T0,  R_P00, R_RN,  1'b0);
			7'd21: u = mk_uop(OP_ADD, R_T1,  R_P11, R_RN,  1'b0);
			7'd22: u = mk_uop(OP_MUL, R_T2,  R_T0,  R_T1,  1'b0);
			7'd23: u = mk_uop(OP_MUL, R_T3,  R_P01, R_P10, 1'b0);
			7'd24: u = mk_uop(OP_SUB, R_T2,  R_T2,  R_T3,  1'b0);
			7'd25: u = mk_uop(OP_CHKZ, R_ZERO, R_T2, R_ZERO, 1'b0);
			// measured velocity and innovations
			7'd26: u = mk_uop(OP_SUB, R_T3,  R_U,   R_LFP, 1'b0);
			7'd27: u = mk_uop(OP_DIV, R_T3,  R_T3,  R_DT,  1'b0);
			7'd28: u = mk_uop(OP_SUB, R_T4,  R_U,   R_POS, 1'b0);
			7'd29: u = mk_uop(OP_SUB, R_T3,  R_T3,  R_VEL, 1'b0);
			// gain
			7'd30: u = mk_uop(OP_MUL, R_T5,  R_P00, R_T1,  1'b0);
			7'd31: u = mk_uop(OP_MUL, R_T6,  R_P01, R_P10, 1'b0);
			7'd32: u = mk_uop(OP_SUB, R_T5,  R_T5,  R_T6,  1'b0);
			7'd33: u = mk_uop(OP_DIV, R_T5,  R_T5,  R_T2,  1'b0);
			7'd34: u = mk_uop(OP_MUL, R_T6,  R_P01, R_T0,  1'b0);
			7'd35: u = mk_uop(OP_MUL, R_T7,  R_P00, R_P01, 1'b0);
			7'd36: u = mk_uop(OP_SUB, R_T6,  R_T6,  R_T7,  1'b0);
			7'd37: u = mk_uop(OP_DIV, R_T6,  R_T6,  R_T2,  1'b0);
			7'd38: u = mk_uop(OP_MUL, R_T7,  R_P10, R_T1,  1'b0);
			7'd39: u = mk_uop(OP_MUL, R_T8,  R_P11, R_P10, 1'b0);
			7'd40: u = mk_uop(OP_SUB, R_T7,  R_T7,  R_T8,  1'b0);
			7'd41: u = mk_uop(OP_DIV, R_T7,  R_T7,  R_T2,  1'b0);
			7'd42: u = mk_uop(OP_MUL, R_T8,  R_P11, R_T0,  1'b0);
			7'd43: u = mk_uop(OP_MUL, R_T9,  R_P10, R_P01, 1'b0);
			7'd44: u = mk_uop(OP_SUB, R_T8,  R_T8,  R_T9,  1'b0);
			7'd45: u = mk_uop(OP_DIV, R_T8,  R_T8,  R_T2,  1'b0);
			// state correction
			7'd46: u = mk_uop(OP_MUL, R_T9,  R_T5,  R_T4,  1'b0);
			7'd47: u = mk_uop(OP_MUL, R_T10, R_T6,  R_T3,  1'b0);
			7'd48: u = mk_uop(OP_ADD, R_T9,  R_T9,  R_T10, 1'b0);
			7'd49: u = mk_uop(OP_ADD, R_POS, R_POS, R_T9,  1'b0);
			7'd50: u = mk_uop(OP_ADD, R_LFP, R_POS, R_ZERO, 1'b0);
			7'd51: u = mk_uop(OP_MUL, R_T9,  R_T7,  R_T4,  1'b0);
			7'd52: u = mk_uop(OP_MUL, R_T10, R_T8,  R_T3,  1'b0);
			7'd53: u = mk_uop(OP_ADD, R_T9,  R_T9,  R_T10, 1'b0);
			7'd54: u = mk_uop(OP_ADD, R_VEL, R_VEL, R_T9,  1'b0);
			// covariance correction, old entries kept until last use
			7'd55: u = mk_uop(OP_MUL, R_T9,  R_T5,  R_P00, 1'b0);
			7'd56: u = mk_uop(OP_MUL, R_T10, R_T6,  R_P10, 1'b0);
			7'd57: u = mk_uop(OP_ADD, R_T9,  R_T9,  R_T10, 1'b0);
			7'd58: u = mk_uop(OP_SUB, R_T9,  R_P00, R_T9,  1'b0);
			7'd59: u = mk_uop(OP_MUL, R_T10, R_T5,  R_P01, 1'b0);
			7'd60: u = mk_uop(OP_MUL, R_T11, R_T6,  R_P11, 1'b0);
			7'd61: u = mk_uop(OP_ADD, R_T10, R_T10, R_T11, 1'b0);
			7'd62: u = mk_uop(OP_SUB, R_T10, R_P01, R_T10, 1'b0);
			7'd63: u = mk_uop(OP_MUL, R_T11, R_T7,  R_P00, 1'b0);
			7'd64: u = mk_uop(OP_MUL, R_T12, R_T8,  R_P10, 1'b0);
			7'd65: u = mk_uop(OP_ADD, R_T11, R_T11, R_T12, 1'b0);
			7'd66: u = mk_uop(OP_SUB, R_P10, R_P10, R_T11, 1'b0);
			7'd67: u = mk_uop(OP_MUL, R_T11, R_T7,  R_P01, 1'b0);
			7'd68: u = mk_uop(OP_MUL, R_T12, R_T8,  R_P11, 1'b0);
			7'd69: u = mk_uop(OP_ADD, R_T11, R_T11, R_T12, 1'b0);
			7'd70: u = mk_uop(OP_SUB, R_P11, R_P11, R_T11, 1'b0);
			7'd71: u = mk_uop(OP_ADD, R_P00, R_T9,  R_ZERO, 1'b0);
			7'd72: u = mk_uop(OP_ADD, R_P01, R_T10, R_ZERO, 1'b1);
			default: u = mk_uop(OP_ADD, R_T12, R_ZERO, R_ZERO, 1'b1);
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

/* design/kpv_alu.sv */
`default_nettype none
module kpv_alu (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire kpv_pkg::alu_req_t req,
	output kpv_pkg::alu_rsp_t      rsp
);

	localparam logic signed [63:0] MAX64 = 64'sd2147483647;
	localparam logic signed [63:0] MIN64 = -64'sd2147483648;
	localparam logic [kpv_pkg::DIV_W-1:0] QMAX_POS =
		kpv_pkg::DIV_W'(32'h7fffffff);
	localparam logic [kpv_pkg::DIV_W-1:0] QMAX_NEG =
		kpv_pkg::DIV_W'(33'h100000000 >> 1);

	logic                         done_q;
	logic                         mul_q;
	logic                         div_q;
	logic [kpv_pkg::CNT_W-1:0]    cnt_q;
	kpv_pkg::word_t               res_q;
	logic                         rsat_q;
	logic signed [63:0]           prod_s1;
	logic [31:0]                  rem_q;
	logic [31:0]                  dvs_q;
	logic [kpv_pkg::DIV_W-1:0]    quo_q;
	logic                         neg_q;
	logic                         dz_q;

	// Saturating add and subtract
	logic [32:0]    as_sum;
	logic           as_ovf;
	kpv_pkg::word_t as_res;
	always_comb begin
		if (req.op == kpv_pkg::OP_SUB) begin
			as_sum = {req.a[31], req.a} - {req.b[31], req.b};
		end else begin
			as_sum = {req.a[31], req.a} + {req.b[31], req.b};
		end
		as_ovf = as_sum[32] ^ as_sum[31];
		if (as_ovf) begin
			as_res = as_sum[32] ? kpv_pkg::WORD_MIN : kpv_pkg::WORD_MAX;
		end else begin
			as_res = as_sum[31:0];
		end
	end

	// Product registered in prod_s1, then rounded half up and saturated into the result register
	logic signed [63:0] mul_full;
	logic signed [63:0] mul_rnd;
	logic signed [63:0] mul_shr;
	logic               mul_ovf;
	kpv_pkg::word_t     mul_res;
	assign mul_full = req.a * req.b;
	always_comb begin
		mul_rnd = prod_s1 + 64'(kpv_pkg::Q_HALF);
		mul_shr = mul_rnd >>> kpv_pkg::FRAC_BITS;
		mul_ovf = (mul_shr > MAX64) || (mul_shr < MIN64);
		if (mul_ovf) begin
			mul_res = mul_shr[63] ? kpv_pkg::WORD_MIN : kpv_pkg::WORD_MAX;
		end else begin
			mul_res = mul_shr[31:0];
		end
	end

	// Restoring division on magnitudes, one quotient bit a cycle
	logic [31:0]               na;
	logic [31:0]               nb;
	logic [32:0]               rem_sh;
	logic                      rem_ge;
	logic [32:0]               rem_df;
	logic [31:0]               rem_nx;
	logic [kpv_pkg::DIV_W-1:0] quo_nx;
	logic                      div_ovf;
	kpv_pkg::word_t            div_res;
	always_comb begin
		na     = req.a[31] ? 32'(-req.a) : 32'(req.a);
		nb     = req.b[31] ? 32'(-req.b) : 32'(req.b);
		rem_sh = {rem_q, quo_q[kpv_pkg::DIV_W-1]};
		rem_ge = rem_sh >= {1'b0, dvs_q};
		rem_df = rem_sh - {1'b0, dvs_q};
		rem_nx = rem_ge ? rem_df[31:0] : rem_sh[31:0];
		quo_nx = {quo_q[kpv_pkg::DIV_W-2:0], rem_ge};
		div_ovf = 1'b0;
		div_res = '0;
		if (dz_q) begin
			div_res = '0;
		end else if (!neg_q) begin
			if (quo_q > QMAX_POS) begin
				div_ovf = 1'b1;
				div_res = kpv_pkg::WORD_MAX;
			end else begin
				div_res = quo_q[31:0];
			end
		end else begin
			if (quo_q > QMAX_NEG) begin
				div_ovf = 1'b1;
				div_res = kpv_pkg::WORD_MIN;
			end else begin
				div_res = 32'(-quo_q[31:0]);
			end
		end
	end

	// Sequence control of the unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			mul_q  <= 1'b0;
			div_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				case (req.op)
					kpv_pkg::OP_MUL: mul_q <= 1'b1;
					kpv_pkg::OP_DIV: begin
						div_q <= 1'b1;
						cnt_q <= kpv_pkg::CNT_W'(kpv_pkg::DIV_W);
					end
					default: done_q <= 1'b1;
				endcase
			end else if (mul_q) begin
				mul_q  <= 1'b0;
				done_q <= 1'b1;
			end else if (div_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					div_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			case (req.op)
				kpv_pkg::OP_ADD, kpv_pkg::OP_SUB: begin
					res_q  <= as_res;
					rsat_q <= as_ovf;
				end
				kpv_pkg::OP_MUL: prod_s1 <= mul_full;
				kpv_pkg::OP_DIV: begin
					quo_q <= {na, {kpv_pkg::FRAC_BITS{1'b0}}};
					rem_q <= '0;
					dvs_q <= nb;
					neg_q <= req.a[31] ^ req.b[31];
					dz_q  <= (req.b == '0);
				end
				default: begin
					res_q  <= '0;
					rsat_q <= 1'b0;
				end
			endcase
		end else if (mul_q) begin
			res_q  <= mul_res;
			rsat_q <= mul_ovf;
		end else if (div_q) begin
			if (cnt_q != '0) begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
			end else begin
				res_q  <= div_res;
				rsat_q <= div_ovf;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;
	assign rsp.sat  = rsat_q;

endmodule
`default_nettype wire

/* design/kpv_regfile.sv */
`default_nettype none
module kpv_regfile (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire kpv_pkg::rf_wr_t  wr,
	input  wire kpv_pkg::ridx_t   rd_a_idx,
	input  wire kpv_pkg::ridx_t   rd_b_idx,
	output kpv_pkg::word_t        rd_a,
	output kpv_pkg::word_t        rd_b,
	output kpv_pkg::word_t        pos,
	output kpv_pkg::word_t        vel
);

	kpv_pkg::word_t rf_q [32];
	kpv_pkg::word_t rd_a_q;
	kpv_pkg::word_t rd_b_q;

	// State, registers, operands and temporaries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 32; i++) begin
				rf_q[i] <= '0;
			end
			rf_q[kpv_pkg::R_P00]  <= kpv_pkg::RESET_COV;
			rf_q[kpv_pkg::R_P11]  <= kpv_pkg::RESET_COV;
			rf_q[kpv_pkg::R_QN]   <= kpv_pkg::RESET_PROCESS;
			rf_q[kpv_pkg::R_RN]   <= kpv_pkg::RESET_SENSOR;
			rf_q[kpv_pkg::R_HALF] <= kpv_pkg::Q_HALF;
		end else begin
			if (wr.cfg_en) begin
				case (wr.cfg_idx)
					kpv_pkg::CFG_PROCESS: rf_q[kpv_pkg::R_QN] <= {1'b0, wr.cfg_data};
					kpv_pkg::CFG_SENSOR:  rf_q[kpv_pkg::R_RN] <= {1'b0, wr.cfg_data};
					kpv_pkg::CFG_INITCOV: begin
						rf_q[kpv_pkg::R_P00] <= {1'b0, wr.cfg_data};
						rf_q[kpv_pkg::R_P11] <= {1'b0, wr.cfg_data};
					end
					default: ;
				endcase
			end
			if (wr.ld_en) begin
				rf_q[kpv_pkg::R_U]  <= wr.ld_u;
				rf_q[kpv_pkg::R_DT] <= wr.ld_dt;
			end
			if (wr.alu_en) begin
				rf_q[wr.alu_idx] <= wr.alu_data;
			end
		end
	end

	// Registered operand reads
	always_ff @(posedge clk) begin
		rd_a_q <= rf_q[rd_a_idx];
		rd_b_q <= rf_q[rd_b_idx];
	end

	assign rd_a = rd_a_q;
	assign rd_b = rd_b_q;
	assign pos  = rf_q[kpv_pkg::R_POS];
	assign vel  = rf_q[kpv_pkg::R_VEL];

endmodule
`default_nettype wire

/* design/position_velocity_kalman.sv */
`default_nettype none
// Channel  Dir  Handshake                Payload
// cfg      in   cfg_valid / cfg_ready    cfg_index, cfg_data (one register write)
// s_axis   in   s_tvalid / s_tready      s_tdata, s_tuser (predict or update item)
// m_axis   out  m_tvalid / m_tready      m_tdata, m_tuser (estimate and status)
//
// Each micro-step reads two operands, runs the shared unit and writes back; a divide
// takes one quotient bit a cycle. A singular update stops at the determinant check; an
// item with a non-positive interval goes from accept straight to the hand-off state.
// s_tready and cfg_ready are high only while the sequencer is idle; a result waits in
// the output register, and the next item is taken meanwhile. Reset loads the register
// file and the sequencer at once; the output payload is not reset.
module position_velocity_kalman (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [30:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // sample_value [31:0], sample_time [63:32]
	input  wire logic [0:0]  s_tuser,   // req_type [0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // est_position [31:0], est_velocity [63:32]
	output logic [1:0]       m_tuser    // status [1:0]
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_EXEC = 5'b00100,
		ST_WAIT = 5'b01000,
		ST_DONE = 5'b10000
	} seq_state_t;

	seq_state_t        state_q;
	kpv_pkg::pc_t      pc_q;
	logic              sat_q;
	logic [1:0]        status_q;
	logic [31:0]       lit_q;
	logic [31:0]       lft_q;
	logic              m_tvalid_q;
	logic [63:0]       m_tdata_q;
	logic [1:0]        m_tuser_q;

	kpv_pkg::uop_t     uop;
	kpv_pkg::alu_req_t alu_req;
	kpv_pkg::alu_rsp_t alu_rsp;
	kpv_pkg::rf_wr_t   rf_wr;
	kpv_pkg::word_t    rd_a;
	kpv_pkg::word_t    rd_b;
	kpv_pkg::word_t    pos;
	kpv_pkg::word_t    vel;

	logic        accept;
	logic        out_load;
	logic [31:0] t_in;
	logic [31:0] dt_sel;
	logic        dt_ok;

	// Intervals since the previous item and the previous fix
	assign t_in   = s_tdata[63:32];
	assign dt_sel = s_tuser[0] ? (t_in - lft_q) : (t_in - lit_q);
	assign dt_ok  = !dt_sel[31] && (dt_sel != '0);

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_load  = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	assign uop = kpv_pkg::ucode(pc_q);

	// Drive the shared unit and the register file
	always_comb begin
		alu_req.start = (state_q == ST_EXEC) && (uop.op != kpv_pkg::OP_CHKZ);
		alu_req.op    = uop.op;
		alu_req.a     = rd_a;
		alu_req.b     = rd_b;

		rf_wr.alu_en   = (state_q == ST_WAIT) && alu_rsp.done;
		rf_wr.alu_idx  = uop.dst;
		rf_wr.alu_data = alu_rsp.res;
		rf_wr.ld_en    = accept;
		rf_wr.ld_u     = s_tdata[31:0];
		rf_wr.ld_dt    = dt_sel;
		rf_wr.cfg_en   = cfg_valid && cfg_ready;
		rf_wr.cfg_idx  = cfg_index;
		rf_wr.cfg_data = cfg_data;
	end

	kpv_regfile u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (rf_wr),
		.rd_a_idx (uop.sa),
		.rd_b_idx (uop.sb),
		.rd_a     (rd_a),
		.rd_b     (rd_b),
		.pos      (pos),
		.vel      (vel)
	);

	kpv_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	// Sequencer: step through the microprogram, then hand the result on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pc_q       <= '0;
			sat_q      <= 1'b0;
			status_q   <= kpv_pkg::STAT_OK;
			lit_q      <= '0;
			lft_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						lit_q <= t_in;
						if (s_tuser[0]) begin
							lft_q <= t_in;
						end
						if (dt_ok) begin
							pc_q    <= s_tuser[0] ? kpv_pkg::UPD_START : kpv_pkg::PRED_START;
							sat_q   <= 1'b0;
							state_q <= ST_READ;
						end else begin
							status_q <= kpv_pkg::STAT_SKIP;
							state_q  <= ST_DONE;
						end
					end
				end
				ST_READ: state_q <= ST_EXEC;
				ST_EXEC: begin
					if (uop.op == kpv_pkg::OP_CHKZ) begin
						if (rd_a == '0) begin
							status_q <= kpv_pkg::STAT_SKIP;
							state_q  <= ST_DONE;
						end else begin
							pc_q    <= pc_q + 1'b1;
							state_q <= ST_READ;
						end
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (alu_rsp.done) begin
						sat_q <= sat_q | alu_rsp.sat;
						if (uop.last) begin
							status_q <= (sat_q | alu_rsp.sat) ? kpv_pkg::STAT_SAT
								: kpv_pkg::STAT_OK;
							state_q  <= ST_DONE;
						end else begin
							pc_q    <= pc_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {vel, pos};
			m_tuser_q <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
`default_nettype wire

/* sim/kpv_checker.sv */
`timescale 1ns / 100ps
`default_nettype none
module kpv_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [30:0] cfg_data,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [63:0] s_tdata,
	input  wire logic [0:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [63:0] m_tdata,
	input  wire logic [1:0]  m_tuser,
	output int               fail_count,
	output int               pending
);

	typedef struct {
		logic [31:0] pos;
		logic [31:0] vel;
		logic [1:0]  stat;
	} estimate_t;

	localparam longint Q_ONE_L  = longint'(1) << kpv_pkg::FRAC_BITS;
	localparam longint Q_HALF_L = longint'(1) << (kpv_pkg::FRAC_BITS - 1);
	localparam longint MAX_L    = 64'sd2147483647;
	localparam longint MIN_L    = -64'sd2147483648;

	// filter state mirrored from the block
	longint q_noise, r_noise, init_cov;
	longint pos, vel, lfp;
	longint cov [4];
	logic [31:0] fix_time, item_time;
	bit clipped;
	estimate_t estimates [$];

	function automatic longint clip(longint v);
		if (v > MAX_L) begin
			clipped = 1;
			return MAX_L;
		end
		if (v < MIN_L) begin
			clipped = 1;
			return MIN_L;
		end
		return v;
	endfunction

	function automatic longint qadd(longint a, longint b);
		return clip(a + b);
	endfunction

	function automatic longint qsub(longint a, longint b);
		return clip(a - b);
	endfunction

	// round half up: >>> on longint floors
	function automatic longint qmul(longint a, longint b);
		return clip((a * b + Q_HALF_L) >>> kpv_pkg::FRAC_BITS);
	endfunction

	function automatic longint qdiv(longint a, longint b);
		if (b == 0)
			return 0;
		return clip((a * Q_ONE_L) / b);
	endfunction

	function automatic logic [1:0] run_predict(longint u, logic [31:0] t);
		longint dt, p00, p01, p10, p11, acc;
		dt  = longint'($signed(t - item_time));
		p00 = cov[0];
		p01 = cov[1];
		p10 = cov[2];
		p11 = cov[3];
		if (dt <= 0)
			return kpv_pkg::STAT_SKIP;
		acc = qmul(qmul(qmul(dt, dt), u), Q_HALF_L);
		pos = qadd(qadd(pos, qmul(vel, dt)), acc);
		vel = qadd(vel, qmul(dt, u));
		acc = qadd(p00, qmul(p10, dt));
		acc = qadd(acc, qmul(p01, dt));
		acc = qadd(acc, qmul(qmul(p11, dt), dt));
		cov[0] = qadd(acc, q_noise);
		cov[1] = qadd(p01, qmul(p11, dt));
		cov[2] = qadd(p10, qmul(p11, dt));
		cov[3] = qadd(p11, q_noise);
		return kpv_pkg::STAT_OK;
	endfunction

	function automatic logic [1:0] run_update(longint meas, logic [31:0] t);
		longint dt, p00, p01, p10, p11, s00, s11, det;
		longint k00, k01, k10, k11, mv, ip, iv;
		dt  = longint'($signed(t - fix_time));
		p00 = cov[0];
		p01 = cov[1];
		p10 = cov[2];
		p11 = cov[3];
		fix_time = t;
		if (dt <= 0)
			return kpv_pkg::STAT_SKIP;
		s00 = qadd(p00, r_noise);
		s11 = qadd(p11, r_noise);
		det = qsub(qmul(s00, s11), qmul(p01, p10));
		if (det == 0)
			return kpv_pkg::STAT_SKIP;
		mv = qdiv(qsub(meas, lfp), dt);
		ip = qsub(meas, pos);
		iv = qsub(mv, vel);
		k00 = qdiv(qsub(qmul(p00, s11), qmul(p01, p10)), det);
		k01 = qdiv(qsub(qmul(p01, s00), qmul(p00, p01)), det);
		k10 = qdiv(qsub(qmul(p10, s11), qmul(p11, p10)), det);
		k11 = qdiv(qsub(qmul(p11, s00), qmul(p10, p01)), det);
		pos = qadd(pos, qadd(qmul(k00, ip), qmul(k01, iv)));
		vel = qadd(vel, qadd(qmul(k10, ip), qmul(k11, iv)));
		lfp = pos;
		cov[0] = qsub(p00, qadd(qmul(k00, p00), qmul(k01, p10)));
		cov[1] = qsub(p01, qadd(qmul(k00, p01), qmul(k01, p11)));
		cov[2] = qsub(p10, qadd(qmul(k10, p00), qmul(k11, p10)));
		cov[3] = qsub(p11, qadd(qmul(k10, p01), qmul(k11, p11)));
		return kpv_pkg::STAT_OK;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		estimate_t e, want;
		logic [1:0] st;
		longint v;
		if (!arst_n) begin
			q_noise   = kpv_pkg::RESET_PROCESS;
			r_noise   = kpv_pkg::RESET_SENSOR;
			init_cov  = kpv_pkg::RESET_COV;
			pos       = 0;
			vel       = 0;
			lfp       = 0;
			cov[0]    = kpv_pkg::RESET_COV;
			cov[1]    = 0;
			cov[2]    = 0;
			cov[3]    = kpv_pkg::RESET_COV;
			fix_time  = '0;
			item_time = '0;
			estimates.delete();
			fail_count = 0;
		end else begin
			// apply register writes
			if (cfg_valid && cfg_ready) begin
				v = longint'(cfg_data);
				case (cfg_index)
					kpv_pkg::CFG_PROCESS: q_noise = v;
					kpv_pkg::CFG_SENSOR:  r_noise = v;
					kpv_pkg::CFG_INITCOV: begin
						init_cov = v;
						cov[0]   = v;
						cov[3]   = v;
					end
					default: ;
				endcase
			end
			// predict the estimate for each accepted item
			if (s_tvalid && s_tready) begin
				clipped = 0;
				v = longint'($signed(s_tdata[31:0]));
				if (s_tuser[0] == 1'b0)
					st = run_predict(v, s_tdata[63:32]);
				else
					st = run_update(v, s_tdata[63:32]);
				item_time = s_tdata[63:32];
				if (st == kpv_pkg::STAT_OK && clipped)
					st = kpv_pkg::STAT_SAT;
				e.pos  = pos[31:0];
				e.vel  = vel[31:0];
				e.stat = st;
				estimates.push_back(e);
			end
			// compare each result transfer with the oldest estimate
			if (m_tvalid && m_tready) begin
				if (estimates.size() == 0) begin
					report_mismatch("unexpected result", m_tdata[31:0], '0);
				end else begin
					want = estimates.pop_front();
					if (m_tdata[31:0] !== want.pos)
						report_mismatch("est_position", m_tdata[31:0], want.pos);
					if (m_tdata[63:32] !== want.vel)
						report_mismatch("est_velocity", m_tdata[63:32], want.vel);
					if (m_tuser !== want.stat)
						report_mismatch("status", 32'(m_tuser), 32'(want.stat));
				end
			end
		end
		pending = estimates.size();
	end

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

	localparam int N_RANDOM   = 1000;
	localparam int IDLE_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [30:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic [63:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tready = 1'b0;
	wire logic   cfg_ready, s_tready, m_tvalid;
	wire logic [63:0] m_tdata;
	wire logic [1:0]  m_tuser;
	int fail_count, pending;

	bit   calm;
	bit   hold_off;
	logic [31:0] clock_now;
	int   idle_cycles = 0;

	always #4 clk = ~clk;

	position_velocity_kalman DUT (.*);

	kpv_checker u_checker (.*);

	// receiver: random stalls, one long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				for (n = 0; n < 2000; n++)
					@(posedge clk);
				hold_off = 0;
			end
			m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// one register write, then the channel is left quiet
	task automatic write_reg(kpv_pkg::cfg_idx_t idx, logic [30:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// send one item, idling beforehand at random; tvalid stays up for the next item
	task automatic send_item(logic kind, logic [31:0] value, logic [31:0] stamp);
		while (!calm && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {stamp, value};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
			default: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
		endcase
	endfunction

	// timestamps mostly advance by small steps, sometimes repeat, jump or go back
	function automatic logic [31:0] next_stamp();
		case ($urandom_range(19))
			0: return clock_now;
			1: return clock_now - $urandom_range(1, 1 << 16);
			2: return $urandom;
			default: return clock_now + $urandom_range(1, 1 << 14);
		endcase
	endfunction

	initial begin
		int i;
		logic [31:0] t;
		calm = 1;
		hold_off = 0;
		clock_now = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, skips and extremes
		send_item(1'b0, 32'h0001_0000, 32'h0);
		send_item(1'b1, 32'h0, 32'h0);
		send_item(1'b0, 32'h0002_0000, 32'h0000_1000);
		send_item(1'b1, 32'h0001_0000, 32'h0000_2000);
		send_item(1'b0, 32'h7fff_ffff, 32'h0001_0000);
		send_item(1'b0, 32'h8000_0000, 32'h0002_0000);
		send_item(1'b1, 32'h7fff_ffff, 32'h0003_0000);
		send_item(1'b1, 32'h8000_0000, 32'h0004_0000);
		send_item(1'b0, 32'h0, 32'hffff_ffff);
		send_item(1'b0, 32'h0, 32'h8000_0000);
		send_item(1'b1, 32'h1234_5678, 32'h0000_0001);
		send_item(1'b1, 32'hffff_0000, 32'h7fff_ffff);
		drain();

		// zero noise and covariance: singular innovation matrix
		write_reg(kpv_pkg::CFG_PROCESS, '0);
		write_reg(kpv_pkg::CFG_SENSOR, '0);
		write_reg(kpv_pkg::CFG_INITCOV, '0);
		send_item(1'b1, 32'h0003_0000, 32'h8100_0000);
		send_item(1'b0, 32'h0, 32'h8200_0000);
		send_item(1'b1, 32'h0003_0000, 32'h8300_0000);
		drain();

		// largest settings
		write_reg(kpv_pkg::CFG_PROCESS, 31'h7fff_ffff);
		write_reg(kpv_pkg::CFG_SENSOR, 31'h7fff_ffff);
		write_reg(kpv_pkg::CFG_INITCOV, 31'h7fff_ffff);
		send_item(1'b0, 32'h0000_8000, 32'h8400_0000);
		send_item(1'b1, 32'h0010_0000, 32'h8500_0000);
		send_item(1'b1, 32'hfff0_0000, 32'h8600_0000);
		drain();

		// receiver holds off while items keep coming
		write_reg(kpv_pkg::CFG_PROCESS, 31'd1966);
		write_reg(kpv_pkg::CFG_SENSOR, 31'd6554);
		write_reg(kpv_pkg::CFG_INITCOV, 31'd32768);
		hold_off = 1;
		clock_now = 32'h9000_0000;
		for (i = 0; i < 6; i++) begin
			clock_now += 32'h100;
			send_item(i[0], rand_value(), clock_now);
		end
		drain();

		// random phases with a fresh setting each
		calm = 0;
		for (i = 0; i < N_RANDOM; i++) begin
			if (i % 200 == 0) begin
				drain();
				write_reg(kpv_pkg::CFG_PROCESS, 31'($urandom_range(0, 1 << 12)));
				write_reg(kpv_pkg::CFG_SENSOR, ($urandom_range(9) == 0) ? 31'($urandom)
					: 31'($urandom_range(0, 1 << 17)));
				write_reg(kpv_pkg::CFG_INITCOV, 31'($urandom_range(0, 1 << 17)));
				calm = (i == 400);
			end
			t = next_stamp();
			if ($signed(t - clock_now) > 0)
				clock_now = t;
			send_item($urandom_range(2) == 0, rand_value(), t);
		end
		drain();

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
